@@ src/lnrast_pkg.sv @@
// ----------------------------------------------------------------------------
// lnrast_pkg
// Shared types and constants of the line rasterizer: field widths and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lnrast_pkg;

  localparam int CoordW = 6;
  localparam int ColorW = 24;
  localparam int ErrW   = 14;
  localparam int GainW  = 7;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [ColorW-1:0] color_t;
  typedef logic [ErrW-1:0]   err_t;
  typedef logic [GainW-1:0]  gain_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Set up a new segment from the input channel.
    logic step;   // Emit one pixel into the output register and advance.
  } lnrast_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;   // The segment still has pixels to emit.
    logic last;   // The next pixel to emit is the final one.
  } lnrast_status_t;

endpackage

@@ src/line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line rasterizer: one segment in, its pixels out one per transfer.
// ----------------------------------------------------------------------------
// A segment is taken on the input channel when the block is idle. Its pixels
// leave one per cycle through an output register, the final one marked with
// out_last_pixel, while the output channel does not stall. The error stepping
// loop produces one pixel per cycle whenever the output register can take one.
// The next segment is taken while the last pixel of the previous one still
// waits in the output register.
module line_rasterizer
  import lnrast_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  input  color_t in_line_color,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_pixel_x,
  output coord_t out_pixel_y,
  output color_t out_pixel_color,
  output logic   out_last_pixel
);

  lnrast_cmd_t    cmd;
  lnrast_status_t status;

  // Sequencing of segments and output transfers.
  lnrast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Setup, error stepping and the output pixel register.
  lnrast_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .status          (status),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

@@ src/lnrast_ctrl.sv @@
// ----------------------------------------------------------------------------
// lnrast_ctrl
// Controller of the line rasterizer: takes a segment, then steps the
// datapath once per free output slot until the last pixel is out.
// ----------------------------------------------------------------------------
module lnrast_ctrl
  import lnrast_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lnrast_status_t status,
  output lnrast_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // The output register can take a pixel when it is empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.more) begin
          // Segment without pixels.
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          cmd.step = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid follows loads into and transfers out of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/lnrast_dp.sv @@
// ----------------------------------------------------------------------------
// lnrast_dp
// Datapath of the line rasterizer: segment setup, the error-stepping
// registers and the output pixel register.
// ----------------------------------------------------------------------------
module lnrast_dp
  import lnrast_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic           clk,
  input  lnrast_cmd_t    cmd,
  output lnrast_status_t status,
  input  coord_t         in_start_x,
  input  coord_t         in_start_y,
  input  coord_t         in_end_x,
  input  coord_t         in_end_y,
  input  color_t         in_line_color,
  output coord_t         out_pixel_x,
  output coord_t         out_pixel_y,
  output color_t         out_pixel_color,
  output logic           out_last_pixel
);

  localparam coord_t CoordMax = CoordW'(GRID_SIZE - 1);

  coord_t major_pos_r, major_pos_nxt;
  coord_t major_stop_r, major_stop_nxt;
  coord_t minor_pos_r, minor_pos_nxt;
  logic   minor_down_r, minor_down_nxt;
  logic   steep_mode_r, steep_mode_nxt;
  err_t   error_sum_r, error_sum_nxt;
  err_t   error_limit_r, error_limit_nxt;
  gain_t  error_gain_r, error_gain_nxt;
  gain_t  limit_gain_r, limit_gain_nxt;
  color_t held_color_r, held_color_nxt;

  coord_t pixel_x_r, pixel_x_nxt;
  coord_t pixel_y_r, pixel_y_nxt;
  color_t pixel_color_r, pixel_color_nxt;
  logic   last_pixel_r, last_pixel_nxt;

  coord_t sx, sy, ex, ey;
  coord_t adx, ady;
  logic   x_up, y_up, x_down, y_down;
  err_t   sum_add;

  // Coordinates past the grid saturate to its last row or column.
  assign sx = (in_start_x > CoordMax) ? CoordMax : in_start_x;
  assign sy = (in_start_y > CoordMax) ? CoordMax : in_start_y;
  assign ex = (in_end_x   > CoordMax) ? CoordMax : in_end_x;
  assign ey = (in_end_y   > CoordMax) ? CoordMax : in_end_y;

  assign x_up   = ex > sx;
  assign x_down = ex < sx;
  assign y_up   = ey > sy;
  assign y_down = ey < sy;
  assign adx    = x_up ? (ex - sx) : (sx - ex);
  assign ady    = y_up ? (ey - sy) : (sy - ey);

  assign sum_add = error_sum_r + ErrW'(error_gain_r);

  assign status.more = major_pos_r < major_stop_r;
  assign status.last = (major_pos_r + CoordW'(1)) == major_stop_r;

  // Segment setup and per-pixel stepping.
  always_comb begin
    major_pos_nxt   = major_pos_r;
    major_stop_nxt  = major_stop_r;
    minor_pos_nxt   = minor_pos_r;
    minor_down_nxt  = minor_down_r;
    steep_mode_nxt  = steep_mode_r;
    error_sum_nxt   = error_sum_r;
    error_limit_nxt = error_limit_r;
    error_gain_nxt  = error_gain_r;
    limit_gain_nxt  = limit_gain_r;
    held_color_nxt  = held_color_r;
    pixel_x_nxt     = pixel_x_r;
    pixel_y_nxt     = pixel_y_r;
    pixel_color_nxt = pixel_color_r;
    last_pixel_nxt  = last_pixel_r;

    if (cmd.load) begin
      held_color_nxt = in_line_color;
      error_sum_nxt  = '0;
      if (!x_up && !x_down) begin
        // Vertical segment: y steps, x stays put.
        steep_mode_nxt  = 1'b1;
        minor_down_nxt  = 1'b0;
        major_pos_nxt   = y_up ? sy : ey;
        major_stop_nxt  = y_up ? ey : sy;
        minor_pos_nxt   = sx;
        error_gain_nxt  = '0;
        limit_gain_nxt  = '0;
        error_limit_nxt = ErrW'(1);
      end else begin
        minor_down_nxt = !((x_up && y_up) || (x_down && y_down));
        if (ady <= adx) begin
          steep_mode_nxt  = 1'b0;
          major_pos_nxt   = x_up ? sx : ex;
          major_stop_nxt  = x_up ? ex : sx;
          minor_pos_nxt   = x_up ? sy : ey;
          error_gain_nxt  = {ady, 1'b0};
          error_limit_nxt = ErrW'(adx);
          limit_gain_nxt  = {adx, 1'b0};
        end else begin
          steep_mode_nxt  = 1'b1;
          major_pos_nxt   = y_up ? sy : ey;
          major_stop_nxt  = y_up ? ey : sy;
          minor_pos_nxt   = y_up ? sx : ex;
          error_gain_nxt  = {adx, 1'b0};
          error_limit_nxt = ErrW'(ady);
          limit_gain_nxt  = {ady, 1'b0};
        end
      end
    end else if (cmd.step) begin
      pixel_x_nxt     = steep_mode_r ? minor_pos_r : major_pos_r;
      pixel_y_nxt     = steep_mode_r ? major_pos_r : minor_pos_r;
      pixel_color_nxt = held_color_r;
      last_pixel_nxt  = status.last;

      error_sum_nxt = sum_add;
      if (sum_add >= error_limit_r) begin
        minor_pos_nxt   = minor_down_r ? (minor_pos_r - CoordW'(1))
                                       : (minor_pos_r + CoordW'(1));
        error_limit_nxt = error_limit_r + ErrW'(limit_gain_r);
      end
      major_pos_nxt = major_pos_r + CoordW'(1);
    end
  end

  always_ff @(posedge clk) begin
    major_pos_r   <= major_pos_nxt;
    major_stop_r  <= major_stop_nxt;
    minor_pos_r   <= minor_pos_nxt;
    minor_down_r  <= minor_down_nxt;
    steep_mode_r  <= steep_mode_nxt;
    error_sum_r   <= error_sum_nxt;
    error_limit_r <= error_limit_nxt;
    error_gain_r  <= error_gain_nxt;
    limit_gain_r  <= limit_gain_nxt;
    held_color_r  <= held_color_nxt;
    pixel_x_r     <= pixel_x_nxt;
    pixel_y_r     <= pixel_y_nxt;
    pixel_color_r <= pixel_color_nxt;
    last_pixel_r  <= last_pixel_nxt;
  end

  assign out_pixel_x     = pixel_x_r;
  assign out_pixel_y     = pixel_y_r;
  assign out_pixel_color = pixel_color_r;
  assign out_last_pixel  = last_pixel_r;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the line rasterizer. Segments go in through
// the input channel from a queue of pending segments. Each accepted segment
// is expanded into its expected pixels by a Bresenham predictor kept here.
// A monitor compares every pixel transfer, field by field, with the oldest
// expected pixel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lnrast_pkg::*;

  localparam int CycleLimit = 4000000;
  // Output register plus the longest segment, with margin.
  localparam int DrainCycles = 100;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    color_t color;
    bit     drain;  // Hold this segment back until every pixel has arrived.
  } segment_t;

  typedef struct {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  color_t in_line_color = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_pixel_color;
  logic   out_last_pixel;

  segment_t segment_q[$];
  pixel_t   pixel_q[$];
  segment_t next_seg;
  pixel_t   want;
  int       fail_count = 0;
  int       cycle_count = 0;
  int       send_gap = 0;
  int       recv_stall = 0;
  bit       calm = 1'b0;

  line_rasterizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_line_color  (in_line_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expand one segment into its pixels. Coordinates are 6 bits on a 64 grid,
  // so saturation to the grid never changes them.
  function automatic void predict_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                          color_t color);
    int     dx;
    int     dy;
    int     adx;
    int     ady;
    coord_t major_at;
    coord_t major_end;
    coord_t minor_at;
    bit     steep;
    bit     down;
    err_t   err;
    err_t   lim;
    gain_t  gain;
    gain_t  lim_gain;
    pixel_t p;
    dx = int'(ex) - int'(sx);
    dy = int'(ey) - int'(sy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    err = '0;
    if (dx == 0) begin
      // Vertical: walk y upward, x fixed, no error stepping.
      steep = 1'b1;
      down = 1'b0;
      major_at = (sy < ey) ? sy : ey;
      major_end = (sy < ey) ? ey : sy;
      minor_at = sx;
      gain = '0;
      lim_gain = '0;
      lim = err_t'(1);
    end else begin
      // Flat and falling slopes move the minor axis down.
      down = ((dx > 0 && dy > 0) || (dx < 0 && dy < 0)) ? 1'b0 : 1'b1;
      if (ady <= adx) begin
        steep = 1'b0;
        major_at = (sx < ex) ? sx : ex;
        major_end = (sx < ex) ? ex : sx;
        minor_at = (sx < ex) ? sy : ey;
        gain = gain_t'(2 * ady);
        lim = err_t'(adx);
        lim_gain = gain_t'(2 * adx);
      end else begin
        steep = 1'b1;
        major_at = (sy < ey) ? sy : ey;
        major_end = (sy < ey) ? ey : sy;
        minor_at = (sy < ey) ? sx : ex;
        gain = gain_t'(2 * adx);
        lim = err_t'(ady);
        lim_gain = gain_t'(2 * ady);
      end
    end
    while (major_at < major_end) begin
      p.x = steep ? minor_at : major_at;
      p.y = steep ? major_at : minor_at;
      p.color = color;
      err = err + err_t'(gain);
      if (err >= lim) begin
        minor_at = down ? minor_at - 1'b1 : minor_at + 1'b1;
        lim = lim + err_t'(lim_gain);
      end
      major_at = major_at + 1'b1;
      p.last = (major_at < major_end) ? 1'b0 : 1'b1;
      pixel_q.push_back(p);
    end
  endfunction

  // Idle length: mostly none, sometimes short, rarely long; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic coord_t near(coord_t c);
    int v;
    v = int'(c) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return coord_t'(v);
  endfunction

  task automatic add_segment(int sx, int sy, int ex, int ey, int color, bit drain);
    segment_t s;
    s.sx = coord_t'(sx);
    s.sy = coord_t'(sy);
    s.ex = coord_t'(ex);
    s.ey = coord_t'(ey);
    s.color = color_t'(color);
    s.drain = drain;
    segment_q.push_back(s);
  endtask

  // Cycle counter, calm stretches and the timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (cycle_count >= CycleLimit) begin
      $display("** line_rasterizer: FAILED **");
      $finish;
    end
  end

  // Driver: presents pending segments and predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_segment(in_start_x, in_start_y, in_end_x, in_end_y, in_line_color);
        send_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (segment_q.size() != 0 &&
                     !(segment_q[0].drain && pixel_q.size() != 0)) begin
          next_seg = segment_q.pop_front();
          in_start_x <= next_seg.sx;
          in_start_y <= next_seg.sy;
          in_end_x <= next_seg.ex;
          in_end_y <= next_seg.ey;
          in_line_color <= next_seg.color;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else if (recv_stall > 0) begin
      recv_stall = recv_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
    end
  end

  // Monitor: check each pixel transfer against the oldest expected pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel transfer at (%0d,%0d)", out_pixel_x, out_pixel_y);
        fail_count = fail_count + 1;
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
          fail_count = fail_count + 1;
        end
        if (out_pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
          fail_count = fail_count + 1;
        end
        if (out_pixel_color !== want.color) begin
          $error("pixel_color: expected %06h, got %06h", want.color, out_pixel_color);
          fail_count = fail_count + 1;
        end
        if (out_last_pixel !== want.last) begin
          $error("last_pixel: expected %0d, got %0d", want.last, out_last_pixel);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int     kind;
    int     made;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;

    // Directed segments: empty, flat, vertical, diagonal, steep and short.
    add_segment(0, 0, 0, 0, 'h000000, 1'b0);
    add_segment(63, 63, 63, 63, 'hFFFFFF, 1'b0);
    add_segment(0, 0, 63, 0, 'hFFFFFF, 1'b0);
    add_segment(63, 63, 0, 63, 'h000000, 1'b0);
    add_segment(5, 0, 5, 63, 'hA5A5A5, 1'b0);
    add_segment(63, 63, 63, 0, 'h5A5A5A, 1'b1);
    add_segment(30, 40, 30, 41, 'h123456, 1'b0);
    add_segment(0, 0, 63, 63, 'hFF0000, 1'b0);
    add_segment(0, 63, 63, 0, 'h00FF00, 1'b0);
    add_segment(63, 0, 0, 63, 'h0000FF, 1'b0);
    add_segment(63, 63, 0, 0, 'h800001, 1'b0);
    add_segment(10, 0, 20, 63, 'hFEDCBA, 1'b0);
    add_segment(20, 0, 10, 63, 'h7F7F7F, 1'b1);
    add_segment(20, 63, 10, 0, 'h808080, 1'b0);
    add_segment(0, 10, 63, 20, 'h0F0F0F, 1'b0);
    add_segment(63, 10, 0, 20, 'hF0F0F0, 1'b0);
    add_segment(7, 7, 8, 7, 'h010203, 1'b0);
    add_segment(63, 5, 62, 5, 'hC0FFEE, 1'b0);
    add_segment(40, 40, 41, 41, 'h333333, 1'b0);
    add_segment(0, 0, 1, 63, 'hCCCCCC, 1'b0);
    add_segment(63, 0, 62, 63, 'h999999, 1'b0);
    add_segment(12, 12, 12, 12, 'hABCDEF, 1'b0);

    // Random segments: mostly full range, plus short, flat, vertical,
    // empty and diagonal ones; a few wait for the pipeline to drain.
    made = 0;
    while (made < 150) begin
      kind = $urandom_range(0, 99);
      ax = coord_t'($urandom_range(0, 63));
      ay = coord_t'($urandom_range(0, 63));
      bx = coord_t'($urandom_range(0, 63));
      by = coord_t'($urandom_range(0, 63));
      if (kind < 50) begin
        // Full-range endpoints as drawn.
      end else if (kind < 70) begin
        bx = near(ax);
        by = near(ay);
      end else if (kind < 78) begin
        by = ay;
      end else if (kind < 86) begin
        bx = ax;
      end else if (kind < 90) begin
        bx = ax;
        by = ay;
      end else begin
        by = ($urandom_range(0, 1) == 0) ? ay + (bx - ax) : ay - (bx - ax);
      end
      add_segment(int'(ax), int'(ay), int'(bx), int'(by), int'($urandom_range(0, 'hFFFFFF)),
                  (made == 0 || $urandom_range(0, 29) == 0));
      if (!(ax == bx && ay == by)) made = made + 1;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (segment_q.size() != 0 || in_valid) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("** line_rasterizer: PASSED **");
    end else begin
      $display("** line_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lnrast_pkg.sv
src/lnrast_ctrl.sv
src/lnrast_dp.sv
src/line_rasterizer.sv
tb/sv/tb_top.sv
